// ===== rtl/cbbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbbe_pkg
// Shared types and constants of the per-cell bounding box extent block.
// ----------------------------------------------------------------------------
package cbbe_pkg;

    localparam int CELLS       = 4096;
    localparam int COORD_WIDTH = 32;
    localparam int CELL_W      = 12;
    localparam int EXT_W       = 32;
    localparam int CELL_AW     = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [CELL_W-1:0]             cell_t;
    typedef logic [CELL_AW-1:0]            cell_addr_t;
    typedef logic [EXT_W-1:0]              ext_t;

    typedef enum logic [1:0] {
        CMD_INIT     = 2'd0,
        CMD_INTERNAL = 2'd1,
        CMD_BOUNDARY = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    // one memory row holds the whole box of a cell
    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } row_t;

    typedef struct packed {
        logic  load;
        logic  cell_ok;
        cell_t cell_id;
    } merge_ctrl_t;

    function automatic logic cell_in_range(input cell_t c);
        return {{(32-CELL_W){1'b0}}, c} < CELLS;
    endfunction

    function automatic cell_addr_t cell_addr(input cell_t c);
        return CELL_AW'(c);
    endfunction

endpackage

// ===== rtl/cbbe_lane.sv =====
// ----------------------------------------------------------------------------
// cbbe_lane
// One axis lane: widens a stored min/max pair with a coordinate and
// registers the saturated extent of the stored pair.
// ----------------------------------------------------------------------------
module cbbe_lane (
    input  logic             clk,
    input  logic             ext_load,
    input  cbbe_pkg::coord_t coord,
    input  cbbe_pkg::coord_t stored_min,
    input  cbbe_pkg::coord_t stored_max,
    output cbbe_pkg::coord_t new_min,
    output cbbe_pkg::coord_t new_max,
    output cbbe_pkg::ext_t   extent
);

    logic signed [cbbe_pkg::COORD_WIDTH:0] diff;
    logic [63:0]                           diff_wide;
    cbbe_pkg::ext_t                        ext_next;
    cbbe_pkg::ext_t                        ext_reg;

    assign new_min = (coord < stored_min) ? coord : stored_min;
    assign new_max = (coord > stored_max) ? coord : stored_max;

    always_comb
    begin
        diff      = {stored_max[cbbe_pkg::COORD_WIDTH-1], stored_max}
                  - {stored_min[cbbe_pkg::COORD_WIDTH-1], stored_min};
        diff_wide = 64'(diff);
        if (stored_max <= stored_min)
        begin
            ext_next = '0;
        end
        else if (diff_wide > 64'h0000_0000_FFFF_FFFF)
        begin
            ext_next = '1;
        end
        else
        begin
            ext_next = diff_wide[cbbe_pkg::EXT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ext_load)
        begin
            ext_reg <= ext_next;
        end
    end

    assign extent = ext_reg;

endmodule

// ===== rtl/cbbe_merge.sv =====
// ----------------------------------------------------------------------------
// cbbe_merge
// Combines the three lane extents into the largest one and holds the
// result transaction in the output register.
// ----------------------------------------------------------------------------
module cbbe_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cbbe_pkg::merge_ctrl_t ctrl,
    input  cbbe_pkg::ext_t        ext_x,
    input  cbbe_pkg::ext_t        ext_y,
    input  cbbe_pkg::ext_t        ext_z,
    input  logic                  out_stall,
    output logic                  slot_free,
    output logic                  out_valid,
    output cbbe_pkg::cell_t       cell_index,
    output cbbe_pkg::ext_t        max_extent
);

    cbbe_pkg::ext_t  ext_xy;
    cbbe_pkg::ext_t  ext_next;
    logic            valid_reg;
    logic            valid_next;
    cbbe_pkg::cell_t cell_reg;
    cbbe_pkg::ext_t  ext_reg;

    assign slot_free = !valid_reg || !out_stall;

    always_comb
    begin
        ext_xy   = (ext_y > ext_x) ? ext_y : ext_x;
        ext_next = (ext_z > ext_xy) ? ext_z : ext_xy;
        // a cell beyond the table reports zero
        if (!ctrl.cell_ok)
        begin
            ext_next = '0;
        end
        valid_next = valid_reg;
        if (slot_free)
        begin
            valid_next = ctrl.load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load && slot_free)
        begin
            cell_reg <= ctrl.cell_id;
            ext_reg  <= ext_next;
        end
    end

    assign out_valid  = valid_reg;
    assign cell_index = cell_reg;
    assign max_extent = ext_reg;

endmodule

// ===== rtl/cell_bounding_box_extent.sv =====
// ----------------------------------------------------------------------------
// cell_bounding_box_extent
// Per-cell bounding box store with three axis lanes and an extent merge.
// ----------------------------------------------------------------------------
// Steps per item, set by the single port of the box memory:
//   init a write, boundary face a read-modify-write, internal face two of them,
//   read in order read, lane extents, merge, plus any wait for the output register.
// A read result passes the memory read, lane extent and output registers.
// Reset clears the sequencer and output valid only; box memory holds no reset.
module cell_bounding_box_extent (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [11:0] cell_a,
    input  logic [11:0] cell_b,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    input  logic [31:0] coord_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] cell_index,
    output logic [31:0] max_extent
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_A,
        ST_RD_B,
        ST_MOD_B,
        ST_MERGE
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    cbbe_pkg::cmd_t        cmd_in;
    cbbe_pkg::coord_t      x_in;
    cbbe_pkg::coord_t      y_in;
    cbbe_pkg::coord_t      z_in;
    logic                  accept;

    cbbe_pkg::cmd_t        cmd_reg;
    cbbe_pkg::cell_t       cell_a_reg;
    cbbe_pkg::cell_t       cell_b_reg;
    logic                  a_ok_reg;
    logic                  b_ok_reg;
    cbbe_pkg::coord_t      x_reg;
    cbbe_pkg::coord_t      y_reg;
    cbbe_pkg::coord_t      z_reg;

    cbbe_pkg::row_t        mem [cbbe_pkg::CELLS];
    cbbe_pkg::row_t        rdata_reg;
    cbbe_pkg::row_t        wdata;
    cbbe_pkg::row_t        widened;
    cbbe_pkg::cell_addr_t  mem_addr;
    logic                  mem_we;
    logic                  mem_re;

    logic                  ext_load;
    cbbe_pkg::ext_t        ext_x;
    cbbe_pkg::ext_t        ext_y;
    cbbe_pkg::ext_t        ext_z;
    cbbe_pkg::merge_ctrl_t merge_ctrl;
    logic                  slot_free;

    assign cmd_in   = cbbe_pkg::cmd_t'(command);
    assign x_in     = cbbe_pkg::coord_t'($signed(coord_x));
    assign y_in     = cbbe_pkg::coord_t'($signed(coord_y));
    assign z_in     = cbbe_pkg::coord_t'($signed(coord_z));
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd_in != cbbe_pkg::CMD_INIT)
                begin
                    state_next = ST_MOD_A;
                end
            end
            ST_MOD_A:
            begin
                case (cmd_reg)
                    cbbe_pkg::CMD_READ:     state_next = ST_MERGE;
                    cbbe_pkg::CMD_INTERNAL: state_next = ST_RD_B;
                    default:                state_next = ST_IDLE;
                endcase
            end
            ST_RD_B:  state_next = ST_MOD_B;
            ST_MOD_B: state_next = ST_IDLE;
            ST_MERGE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_in;
            cell_a_reg <= cell_a;
            cell_b_reg <= cell_b;
            a_ok_reg   <= cbbe_pkg::cell_in_range(cell_a);
            b_ok_reg   <= cbbe_pkg::cell_in_range(cell_b);
            x_reg      <= x_in;
            y_reg      <= y_in;
            z_reg      <= z_in;
        end
    end

    // memory port control
    always_comb
    begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = cbbe_pkg::cell_addr(cell_a_reg);
        wdata    = widened;
        case (state_reg)
            ST_IDLE:
            begin
                mem_addr = cbbe_pkg::cell_addr(cell_a);
                wdata    = '{min_x: x_in, min_y: y_in, min_z: z_in,
                             max_x: x_in, max_y: y_in, max_z: z_in};
                if (accept)
                begin
                    if (cmd_in == cbbe_pkg::CMD_INIT)
                    begin
                        mem_we = cbbe_pkg::cell_in_range(cell_a);
                    end
                    else
                    begin
                        mem_re = 1'b1;
                    end
                end
            end
            ST_MOD_A:
            begin
                mem_we = a_ok_reg && (cmd_reg == cbbe_pkg::CMD_INTERNAL ||
                                      cmd_reg == cbbe_pkg::CMD_BOUNDARY);
            end
            ST_RD_B:
            begin
                mem_addr = cbbe_pkg::cell_addr(cell_b_reg);
                mem_re   = 1'b1;
            end
            ST_MOD_B:
            begin
                mem_addr = cbbe_pkg::cell_addr(cell_b_reg);
                mem_we   = b_ok_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign ext_load = (state_reg == ST_MOD_A);

    cbbe_lane u_lane_x (
        .clk        (clk),
        .ext_load   (ext_load),
        .coord      (x_reg),
        .stored_min (rdata_reg.min_x),
        .stored_max (rdata_reg.max_x),
        .new_min    (widened.min_x),
        .new_max    (widened.max_x),
        .extent     (ext_x)
    );

    cbbe_lane u_lane_y (
        .clk        (clk),
        .ext_load   (ext_load),
        .coord      (y_reg),
        .stored_min (rdata_reg.min_y),
        .stored_max (rdata_reg.max_y),
        .new_min    (widened.min_y),
        .new_max    (widened.max_y),
        .extent     (ext_y)
    );

    cbbe_lane u_lane_z (
        .clk        (clk),
        .ext_load   (ext_load),
        .coord      (z_reg),
        .stored_min (rdata_reg.min_z),
        .stored_max (rdata_reg.max_z),
        .new_min    (widened.min_z),
        .new_max    (widened.max_z),
        .extent     (ext_z)
    );

    assign merge_ctrl = '{load:    (state_reg == ST_MERGE),
                          cell_ok: a_ok_reg,
                          cell_id: cell_a_reg};

    cbbe_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (merge_ctrl),
        .ext_x      (ext_x),
        .ext_y      (ext_y),
        .ext_z      (ext_z),
        .out_stall  (out_stall),
        .slot_free  (slot_free),
        .out_valid  (out_valid),
        .cell_index (cell_index),
        .max_extent (max_extent)
    );

endmodule

// ===== test/box_extent_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_extent_monitor
// Watches both channels of the bounding box block, keeps its own copy of
// every cell box, predicts the extent of each read and checks the results.
// ----------------------------------------------------------------------------
module box_extent_monitor
    import cbbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [11:0] cell_a,
    input  logic [11:0] cell_b,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    input  logic [31:0] coord_z,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [11:0] cell_index,
    input  logic [31:0] max_extent,
    output int          mismatches,
    output int          compared,
    output int          pending
);

    typedef struct {
        cell_t cell_id;
        ext_t  extent;
    } extent_result_t;

    coord_t lo_x [CELLS];
    coord_t lo_y [CELLS];
    coord_t lo_z [CELLS];
    coord_t hi_x [CELLS];
    coord_t hi_y [CELLS];
    coord_t hi_z [CELLS];

    extent_result_t extent_due [$];

    int fail_count  = 0;
    int match_count = 0;
    int due_count   = 0;

    assign mismatches = fail_count;
    assign compared   = match_count;
    assign pending    = due_count;

    function automatic ext_t span_of(input coord_t lo, input coord_t hi);
        longint diff;
        diff = longint'(hi) - longint'(lo);
        if (diff <= 0)
            return '0;
        if (diff > 64'h0000_0000_FFFF_FFFF)
            return '1;
        return ext_t'(diff);
    endfunction

    function automatic ext_t box_extent(input cell_t c);
        ext_t widest;
        ext_t span;
        if (int'(c) >= CELLS)
            return '0;
        widest = span_of(lo_x[c], hi_x[c]);
        span   = span_of(lo_y[c], hi_y[c]);
        if (span > widest)
            widest = span;
        span   = span_of(lo_z[c], hi_z[c]);
        if (span > widest)
            widest = span;
        return widest;
    endfunction

    // grow one box so that it holds the given point
    task automatic stretch_box(input cell_t c, input coord_t x, input coord_t y,
                               input coord_t z);
        if (int'(c) >= CELLS)
            return;
        if (x < lo_x[c]) lo_x[c] = x;
        if (y < lo_y[c]) lo_y[c] = y;
        if (z < lo_z[c]) lo_z[c] = z;
        if (x > hi_x[c]) hi_x[c] = x;
        if (y > hi_y[c]) hi_y[c] = y;
        if (z > hi_z[c]) hi_z[c] = z;
    endtask

    always @(posedge clk)
    begin : watch
        extent_result_t due;
        cmd_t           op;
        coord_t         x;
        coord_t         y;
        coord_t         z;
        if (rst_n)
        begin
            // a result can never belong to a transaction taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (extent_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: unexpected result cell %0d extent %h",
                                 $realtime, cell_index, max_extent);
                end
                else
                begin
                    due = extent_due.pop_front();
                    match_count++;
                    if (cell_index !== due.cell_id || max_extent !== due.extent)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%t: expected cell %0d extent %h, got cell %0d extent %h",
                                     $realtime, due.cell_id, due.extent, cell_index,
                                     max_extent);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                op = cmd_t'(command);
                x  = coord_t'(coord_x);
                y  = coord_t'(coord_y);
                z  = coord_t'(coord_z);
                case (op)
                    CMD_INIT:
                        if (int'(cell_a) < CELLS)
                        begin
                            lo_x[cell_a] = x;
                            lo_y[cell_a] = y;
                            lo_z[cell_a] = z;
                            hi_x[cell_a] = x;
                            hi_y[cell_a] = y;
                            hi_z[cell_a] = z;
                        end
                    CMD_INTERNAL:
                    begin
                        // same owner and neighbour: second stretch changes nothing
                        stretch_box(cell_a, x, y, z);
                        stretch_box(cell_b, x, y, z);
                    end
                    CMD_BOUNDARY:
                        stretch_box(cell_a, x, y, z);
                    CMD_READ:
                        extent_due.push_back('{cell_a, box_extent(cell_a)});
                    default:
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%t: unknown command %b accepted", $realtime, command);
                    end
                endcase
            end
            due_count = extent_due.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives init, face and read transactions into the bounding box block with
// random gaps and output stalls; a separate monitor predicts and checks.
// ----------------------------------------------------------------------------
module testbench;

    import cbbe_pkg::*;

    localparam int     RANDOM_ITEMS = 1300;
    localparam int     STALL_LIMIT  = 3000;
    localparam int     HOLD_AT      = 300;
    localparam int     HOLD_CYCLES  = 400;
    localparam coord_t COORD_LO     = coord_t'(32'h8000_0000);
    localparam coord_t COORD_HI     = coord_t'(32'h7FFF_FFFF);

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [11:0] cell_a;
    logic [11:0] cell_b;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] cell_index;
    logic [31:0] max_extent;

    int mismatches;
    int compared;
    int pending;

    int items_sent = 0;
    int reads_sent = 0;
    int idle_pct   = 32;
    bit calm       = 1'b0;
    bit seeded [CELLS];

    cell_bounding_box_extent dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .cell_a     (cell_a),
        .cell_b     (cell_b),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_index (cell_index),
        .max_extent (max_extent)
    );

    box_extent_monitor extent_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .cell_a     (cell_a),
        .cell_b     (cell_b),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_index (cell_index),
        .max_extent (max_extent),
        .mismatches (mismatches),
        .compared   (compared),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input cmd_t op, input cell_t a, input cell_t b,
                             input coord_t x, input coord_t y, input coord_t z);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= op;
        cell_a   <= a;
        cell_b   <= b;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (op == CMD_READ)
            reads_sent++;
        if (op == CMD_INIT)
            seeded[a] = 1'b1;
        @(negedge clk);
    endtask

    // small working set most of the time so boxes grow and get read back
    function automatic cell_t pick_cell();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return cell_t'($urandom_range(15));
            6:                return cell_t'(4095 - $urandom_range(3));
            default:          return cell_t'($urandom_range(4095));
        endcase
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(7))
            0:
                case ($urandom_range(3))
                    0:       return COORD_LO;
                    1:       return COORD_HI;
                    2:       return '0;
                    default: return '1;
                endcase
            1, 2:    return coord_t'((int'($urandom_range(8192)) - 4096) * 256);
            default: return coord_t'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        cmd_t  op;
        cell_t a;
        cell_t b;
        int    roll;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        command  = CMD_INIT;
        cell_a   = '0;
        cell_b   = '0;
        coord_x  = '0;
        coord_y  = '0;
        coord_z  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: corner cells, full-range coordinates, every command
        send_item(CMD_INIT, 0, 77, '0, '0, '0);
        send_item(CMD_READ, 0, cell_t'($urandom_range(4095)), $urandom, $urandom, $urandom);
        send_item(CMD_INIT, 4095, 0, COORD_HI, COORD_HI, COORD_HI);
        send_item(CMD_BOUNDARY, 4095, 12'hABC, COORD_LO, '0, coord_t'(1));
        send_item(CMD_READ, 4095, cell_t'($urandom_range(4095)), $urandom, $urandom,
                  $urandom);
        send_item(CMD_INTERNAL, 0, 4095, COORD_LO, COORD_HI, '1);
        send_item(CMD_READ, 0, cell_t'($urandom_range(4095)), $urandom, $urandom, $urandom);
        send_item(CMD_READ, 4095, cell_t'($urandom_range(4095)), $urandom, $urandom,
                  $urandom);
        send_item(CMD_INIT, 1, 12'hFFF, coord_t'(5 * 65536), coord_t'(-7 * 65536),
                  coord_t'(100 * 65536));
        // owner equals neighbour
        send_item(CMD_INTERNAL, 1, 1, coord_t'(-3 * 65536), coord_t'(20 * 65536),
                  coord_t'(100 * 65536));
        send_item(CMD_READ, 1, cell_t'($urandom_range(4095)), $urandom, $urandom, $urandom);
        // point already inside the box
        send_item(CMD_BOUNDARY, 1, 12'hFFF, '0, '0, coord_t'(100 * 65536));
        send_item(CMD_READ, 1, cell_t'($urandom_range(4095)), $urandom, $urandom, $urandom);
        send_item(CMD_INIT, 2, 0, $urandom, $urandom, $urandom);
        send_item(CMD_INTERNAL, 2, 0, $urandom, $urandom, $urandom);
        send_item(CMD_READ, 2, cell_t'($urandom_range(4095)), $urandom, $urandom, $urandom);
        send_item(CMD_READ, 0, cell_t'($urandom_range(4095)), $urandom, $urandom, $urandom);
        // reseeding collapses the box again
        send_item(CMD_INIT, 0, 0, COORD_HI, COORD_LO, '0);
        send_item(CMD_READ, 0, cell_t'($urandom_range(4095)), $urandom, $urandom, $urandom);
        send_item(CMD_READ, 4095, cell_t'($urandom_range(4095)), $urandom, $urandom,
                  $urandom);
        send_item(CMD_READ, 1, cell_t'($urandom_range(4095)), $urandom, $urandom, $urandom);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm     = (n >= 700 && n < 900);
            idle_pct = calm ? 0 : 32;
            roll     = $urandom_range(99);
            if (roll < 15)
                op = CMD_INIT;
            else if (roll < 50)
                op = CMD_INTERNAL;
            else if (roll < 70)
                op = CMD_BOUNDARY;
            else
                op = CMD_READ;
            a = pick_cell();
            b = pick_cell();
            // never touch a box that has not been seeded
            if (!seeded[a])
                op = CMD_INIT;
            else if (op == CMD_INTERNAL && !seeded[b])
            begin
                op = CMD_INIT;
                a  = b;
            end
            if (op != CMD_INTERNAL)
                b = cell_t'($urandom_range(4095));
            send_item(op, a, b, pick_coord(), pick_coord(), pick_coord());
        end
        in_valid <= 1'b0;
        calm     = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("%0d transactions driven, %0d of them extent reads",
                 items_sent, reads_sent);
        $display("%0d extent results compared, %0d mismatches", compared, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // output side: random stalls, one long hold-off, a quiet window
    initial
    begin : receiver
        int hold;
        bit held;
        hold      = 0;
        held      = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && items_sent >= HOLD_AT)
            begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 32);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cbbe_pkg.sv
rtl/cbbe_lane.sv
rtl/cbbe_merge.sv
rtl/cell_bounding_box_extent.sv
test/box_extent_monitor.sv
test/testbench.sv
